// ===== rtl/sha1_pkg.sv =====
package sha1_pkg;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam int unsigned NUM_ROUNDS = 80;
   localparam int unsigned DIGEST_WORDS = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } state_type;

   // datapath commands
   typedef struct packed {
      logic take_byte;   // write request byte into block, bump counters
      logic start_comp;  // load working vars from chain value, clear round
      logic do_round;    // run one compression round
      logic end_comp;    // add working vars into chain value
      logic write_pad;   // write 0x80 and zero the rest of the block
      logic clear_block; // zero the whole block
      logic write_len;   // write bit length into words 14 and 15
      logic reinit;      // restore chain value and counters
   } cmd_type;

   typedef struct packed {
      logic block_full;  // byte count in block wrapped to zero
      logic last_round;  // round counter at 79
      logic pad_spill;   // padding needs an extra block
   } status_type;

   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      if (r < 7'd20) k = K0;
      else if (r < 7'd40) k = K1;
      else if (r < 7'd60) k = K2;
      else k = K3;
      return k;
   endfunction

endpackage

// ===== rtl/sha1_datapath.sv =====
module sha1_datapath (
   input  logic                clock,
   input  logic                reset,
   input  sha1_pkg::cmd_type   cmd,
   input  logic [7:0]          data_byte,
   input  logic [2:0]          out_index,
   output sha1_pkg::status_type status,
   output logic [31:0]         digest_word
);
   import sha1_pkg::*;

   logic [31:0] block_ff [16];
   logic [31:0] chain_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [5:0]  pos_ff;
   logic [60:0] count_ff;
   logic [6:0]  round_ff;

   logic [3:0]  s;
   logic [31:0] w_new, w_cur, f, t;
   logic [63:0] bits;
   logic [3:0]  pidx;
   logic [4:0]  psh;

   always_comb begin
      s = round_ff[3:0];
      w_new = block_ff[s + 4'd13] ^ block_ff[s + 4'd8] ^ block_ff[s + 4'd2] ^ block_ff[s];
      w_new = {w_new[30:0], w_new[31]};
      w_cur = (round_ff >= 7'd16) ? w_new : block_ff[s];
      if (round_ff < 7'd20) f = (b_ff & c_ff) | (~b_ff & d_ff);
      else if (round_ff >= 7'd40 && round_ff < 7'd60)
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
      else f = b_ff ^ c_ff ^ d_ff;
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + round_k(round_ff) + w_cur;
      bits = {count_ff, 3'b000};
      pidx = pos_ff[5:2];
      psh = 5'd24 - {pos_ff[1:0], 3'b000};
   end

   assign status.block_full = (pos_ff == 6'd0);
   assign status.last_round = (round_ff == 7'(NUM_ROUNDS - 1));
   assign status.pad_spill  = (pos_ff >= 6'd56);
   assign digest_word = chain_ff[out_index];

   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         if (pos_ff[1:0] == 2'd0) block_ff[pidx] <= {data_byte, 24'd0};
         else block_ff[pidx] <= block_ff[pidx] | (32'(data_byte) << psh);
      end
      if (cmd.write_pad) begin
         for (int i = 0; i < 16; i++)
            if (4'(i) > pidx) block_ff[i] <= '0;
         if (pos_ff[1:0] == 2'd0) block_ff[pidx] <= {PAD_BYTE, 24'd0};
         else block_ff[pidx] <= block_ff[pidx] | (32'(PAD_BYTE) << psh);
      end
      if (cmd.clear_block)
         for (int i = 0; i < 16; i++) block_ff[i] <= '0;
      if (cmd.write_len) begin
         block_ff[14] <= bits[63:32];
         block_ff[15] <= bits[31:0];
      end
      if (cmd.do_round) begin
         block_ff[s] <= w_cur;
         a_ff <= t;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
      if (cmd.start_comp) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reinit) begin
         chain_ff[0] <= H0;
         chain_ff[1] <= H1;
         chain_ff[2] <= H2;
         chain_ff[3] <= H3;
         chain_ff[4] <= H4;
         pos_ff <= '0;
         count_ff <= '0;
         round_ff <= '0;
      end else begin
         if (cmd.take_byte) begin
            pos_ff <= pos_ff + 6'd1;
            count_ff <= count_ff + 61'd1;
         end
         if (cmd.start_comp) round_ff <= '0;
         else if (cmd.do_round) round_ff <= round_ff + 7'd1;
         if (cmd.end_comp) begin
            // add the working vars as they leave the last round
            chain_ff[0] <= chain_ff[0] + t;
            chain_ff[1] <= chain_ff[1] + a_ff;
            chain_ff[2] <= chain_ff[2] + {b_ff[1:0], b_ff[31:2]};
            chain_ff[3] <= chain_ff[3] + c_ff;
            chain_ff[4] <= chain_ff[4] + d_ff;
            round_ff <= '0;
         end
      end
   end

endmodule

// ===== rtl/sha1_control.sv =====
module sha1_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 in_has,
   input  logic                 in_last,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [2:0]           out_index,
   input  sha1_pkg::status_type status,
   output sha1_pkg::cmd_type    cmd
);
   import sha1_pkg::*;

   state_type state_ff, state_in;
   logic      last_ff, last_in;    // message ends after current compression
   logic      final_ff, final_in;  // current compression is the length block
   logic      pend_ff, pend_in;    // take_byte issued last cycle, check fill
   logic      spill_ff, spill_in;  // current compression is the padding spill block
   logic      ov_ff, ov_in;
   logic [2:0] idx_ff, idx_in;
   logic      acc;

   assign acc = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_index = idx_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      final_in = final_ff;
      spill_in = spill_ff;
      pend_in = 1'b0;
      ov_in = ov_ff;
      idx_in = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pend_ff && status.block_full) begin
               state_in = ST_ROUND;
               final_in = 1'b0;
            end else if (pend_ff && last_ff) begin
               state_in = ST_PAD;
            end else if (acc) begin
               pend_in = in_has;
               last_in = in_last;
               if (in_last && !in_has) state_in = ST_PAD;
            end
         end
         ST_ROUND: begin
            if (status.last_round) begin
               if (final_ff) begin
                  state_in = ST_OUT;
                  idx_in = '0;
                  ov_in = 1'b0;
               end else if (last_ff) state_in = spill_ff ? ST_LEN : ST_PAD;
               else state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (status.pad_spill) state_in = ST_ROUND;
            else begin
               state_in = ST_LEN;
            end
            final_in = 1'b0;
            spill_in = status.pad_spill;
            if (status.pad_spill) last_in = 1'b1;
         end
         ST_LEN: begin
            state_in = ST_ROUND;
            final_in = 1'b1;
            spill_in = 1'b0;
         end
         ST_OUT: begin
            if (!ov_ff || out_ready) begin
               if (ov_ff && idx_ff == 3'(DIGEST_WORDS - 1)) begin
                  ov_in = 1'b0;
                  state_in = ST_IDLE;
                  last_in = 1'b0;
               end else begin
                  ov_in = 1'b1;
                  if (ov_ff) idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = !pend_ff;
            cmd.take_byte = acc && in_has;
            if (pend_ff && status.block_full) cmd.start_comp = 1'b1;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            cmd.end_comp = status.last_round;
         end
         ST_PAD: begin
            cmd.write_pad = 1'b1;
            cmd.start_comp = status.pad_spill;
         end
         ST_LEN: begin
            // after a spill block the block is cleared first
            cmd.clear_block = spill_ff;
            cmd.write_len = 1'b1;
            cmd.start_comp = 1'b1;
         end
         ST_OUT: begin
            cmd.reinit = ov_ff && out_ready && idx_ff == 3'(DIGEST_WORDS - 1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff <= 1'b0;
         final_ff <= 1'b0;
         pend_ff <= 1'b0;
         spill_ff <= 1'b0;
         ov_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
         final_ff <= final_in;
         pend_ff <= pend_in;
         spill_ff <= spill_in;
         ov_ff <= ov_in;
         idx_ff <= idx_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> state_ff == ST_OUT)
      else $error("result valid outside output phase");
   assert property (@(posedge clock) disable iff (reset)
      in_ready |-> !out_valid)
      else $error("input taken while digest pending");
   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(idx_ff))
      else $error("stalled word index changed");

endmodule

// ===== rtl/sha1_message_digest.sv =====
// channel | direction | tdata                         | tuser    | tlast
// req_    | in        | data_byte[7:0]                | has_byte | last_of_message
// rsp_    | out       | digest_word[31:0], word_index | -        | last_word
//
// each byte is written, then the block fill is checked before the next byte is taken; every 64th byte starts
// a compression (one round per cycle in the shared round unit)
// message end adds one or two compressions plus the padding and length writes, then
// five digest items leave one per cycle while rsp_tready is high, straight from the chain value registers
// synchronous active-high reset restores the initial chain value and counters
// req_tready is low during compression and while digest items are pending
module sha1_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tuser,   // has_byte
   input  logic        req_tlast,   // last_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], word_index[34:32], zero fill
   output logic        rsp_tlast    // last_word
);
   import sha1_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [2:0]  idx;
   logic [31:0] word;

   // sequencer for bytes, rounds, padding and digest output
   sha1_control u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_has(req_tuser), .in_last(req_tlast),
      .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_index(idx),
      .status(status), .cmd(cmd)
   );

   // block buffer, round unit and chain value
   sha1_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .data_byte(req_tdata),
      .out_index(idx), .status(status), .digest_word(word)
   );

   assign rsp_tdata = {5'd0, idx, word};
   assign rsp_tlast = (idx == 3'(DIGEST_WORDS - 1));

endmodule
